// ===== rtl/core/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants for the sprite blitter with clipping.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int COORD_W    = 13;
  localparam int DIM_W      = 13;
  localparam int ORG_W      = 12;
  localparam int SPR_CFG_W  = 11;
  localparam int BPP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // limits and defaults
  localparam int MAX_SCREEN_SIDE         = 4096;
  localparam int MAX_SPRITE_SIDE_DEF     = 1024;
  localparam int MAX_BYTES_PER_PIXEL_DEF = 4;
  localparam int QUEUE_DEPTH             = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MODE       = 3'd7;

  // reset values
  localparam logic [DIM_W-1:0] RST_SCREEN_W = 13'd1024;
  localparam logic [DIM_W-1:0] RST_SCREEN_H = 13'd768;
  localparam logic [DIM_W-1:0] RST_SPRITE_W = 13'd1;
  localparam logic [DIM_W-1:0] RST_SPRITE_H = 13'd1;
  localparam int               RST_BPP      = 4;

  // effective configuration, sizes already clamped to their legal ranges
  typedef struct packed {
    logic [DIM_W-1:0] screen_w;
    logic [DIM_W-1:0] screen_h;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [DIM_W-1:0] sprite_w;
    logic [DIM_W-1:0] sprite_h;
    logic [BPP_W-1:0] bpp;
    logic             clip;
  } sbc_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbc_if.sv =====
// ----------------------------------------------------------------------------
// sbc_if
// Valid/ready channel interfaces for source bytes and screen pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_in_if;
  import sbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface sbc_out_if;
  import sbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] color;
  logic               write_enable;
  logic               rejected;
  logic               last;

  modport source (output valid, output pixel_x, output pixel_y, output color,
                  output write_enable, output rejected, output last, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input color,
                input write_enable, input rejected, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front
// Takes source bytes, assembles pixel colors and tracks the raster position.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_front #(
  parameter int MAX_BYTES_PER_PIXEL = sbc_pkg::MAX_BYTES_PER_PIXEL_DEF,
  parameter int CNT_W               = 10,
  parameter int ENTRY_W             = 53
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sbc_pkg::sbc_cfg_t           cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sbc_pkg::BYTE_W-1:0]  in_byte,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [ENTRY_W-1:0]               push_data
);
  import sbc_pkg::*;

  localparam int BI_W  = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
  localparam int ACC_W = BYTE_W * MAX_BYTES_PER_PIXEL;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] line_r, line_nxt;
  logic [BI_W-1:0]  bidx_r, bidx_nxt;
  logic [ACC_W-1:0] accum_r, accum_nxt;

  logic [ACC_W-1:0] acc_new;
  logic [BPP_W-1:0] bi_next;
  logic             pix_done;
  logic             end_row;
  logic             end_sprite;
  logic             accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready;

  // place the byte at its little-endian slot
  assign acc_new  = accum_r | (ACC_W'(in_byte) << {bidx_r, 3'b000});
  assign bi_next  = BPP_W'(bidx_r) + BPP_W'(1);
  assign pix_done = (bi_next >= cfg.bpp);

  assign end_row    = (DIM_W'(col_r) + DIM_W'(1)) >= cfg.sprite_w;
  assign end_sprite = end_row && ((DIM_W'(line_r) + DIM_W'(1)) >= cfg.sprite_h);

  assign push_valid = in_valid && pix_done;
  assign push_data  = {col_r, line_r, COLOR_W'(acc_new), end_sprite};

  always_comb begin
    col_nxt   = col_r;
    line_nxt  = line_r;
    bidx_nxt  = bidx_r;
    accum_nxt = accum_r;
    if (accept) begin
      if (pix_done) begin
        bidx_nxt  = '0;
        accum_nxt = '0;
        if (end_row) begin
          col_nxt  = '0;
          line_nxt = end_sprite ? '0 : line_r + CNT_W'(1);
        end else begin
          col_nxt = col_r + CNT_W'(1);
        end
      end else begin
        bidx_nxt  = BI_W'(bi_next);
        accum_nxt = acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      line_r  <= '0;
      bidx_r  <= '0;
      accum_r <= '0;
    end else begin
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      bidx_r  <= bidx_nxt;
      accum_r <= accum_nxt;
    end
  end

`ifndef SYNTHESIS
  // a finished pixel leaves no partial color behind
  a_pixel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pix_done) |=> (bidx_r == '0 && accum_r == '0))
    else $error("pixel end did not clear byte index or color");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sbc_queue.sv =====
// ----------------------------------------------------------------------------
// sbc_queue
// Short request queue between the pixel assembler and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_queue #(
  parameter int DEPTH = sbc_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 53
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import sbc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_en;
  logic             pop_en;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_en    = push_valid && push_ready;
  assign pop_en     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push_en, pop_en})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && !pop_en) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sbc_back.sv =====
// ----------------------------------------------------------------------------
// sbc_back
// Places each pixel on screen, decides clip or reject, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_back #(
  parameter int CNT_W   = 10,
  parameter int ENTRY_W = 53
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sbc_pkg::sbc_cfg_t            cfg,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire logic [ENTRY_W-1:0]           pop_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sbc_pkg::COORD_W-1:0]       out_pixel_x,
  output logic [sbc_pkg::COORD_W-1:0]       out_pixel_y,
  output logic [sbc_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_write_enable,
  output logic                              out_rejected,
  output logic                              out_last
);
  import sbc_pkg::*;

  localparam int SUM_W = COORD_W + 1;

  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   line;
  logic [COLOR_W-1:0] color;
  logic               last;

  logic [SUM_W-1:0]   px;
  logic [SUM_W-1:0]   py;
  logic [SUM_W-1:0]   right_edge;
  logic [SUM_W-1:0]   bottom_edge;
  logic               fits;
  logic               we;
  logic               rej;
  logic               load;

  logic               out_valid_r;
  logic [COORD_W-1:0] px_r;
  logic [COORD_W-1:0] py_r;
  logic [COLOR_W-1:0] color_r;
  logic               we_r;
  logic               rej_r;
  logic               last_r;

  assign {col, line, color, last} = pop_data;

  assign px          = SUM_W'(cfg.origin_x) + SUM_W'(col);
  assign py          = SUM_W'(cfg.origin_y) + SUM_W'(line);
  assign right_edge  = SUM_W'(cfg.origin_x) + SUM_W'(cfg.sprite_w);
  assign bottom_edge = SUM_W'(cfg.origin_y) + SUM_W'(cfg.sprite_h);
  assign fits        = (right_edge <= SUM_W'(cfg.screen_w)) &&
                       (bottom_edge <= SUM_W'(cfg.screen_h));

  always_comb begin
    if (cfg.clip) begin
      rej = 1'b0;
      we  = (px < SUM_W'(cfg.screen_w)) && (py < SUM_W'(cfg.screen_h));
    end else begin
      rej = !fits;
      we  = fits;
    end
  end

  // output register frees up whenever the sink takes its request
  assign pop_ready = !out_valid_r || out_ready;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= px[COORD_W-1:0];
      py_r    <= py[COORD_W-1:0];
      color_r <= color;
      we_r    <= we;
      rej_r   <= rej;
      last_r  <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_color        = color_r;
  assign out_write_enable = we_r;
  assign out_rejected     = rej_r;
  assign out_last         = last_r;

`ifndef SYNTHESIS
  a_we_rej_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(we_r && rej_r))
    else $error("pixel both written and rejected");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sprite_blit_clip_unit.sv =====
// ----------------------------------------------------------------------------
// sprite_blit_clip_unit
// Sprite blitter: source bytes in raster order to clipped screen pixels.
// ----------------------------------------------------------------------------
//   port     dir  protocol      carries
//   in_ch    in   valid/ready   src_byte, one source byte per request
//   out_ch   out  valid/ready   pixel_x, pixel_y, color, write_enable,
//                               rejected, last, one request per pixel
//   cfg_*    in   write enable  register index and data, no read-back
//
// One source byte is taken per cycle while the request queue has room;
// a pixel leaves after bytes_per_pixel bytes. It reaches out_ch through
// the request queue and then the output register.
// A stalled out_ch fills the two-entry queue, then drops in_ch.ready.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_clip_unit #(
  parameter int MAX_SPRITE_SIDE     = sbc_pkg::MAX_SPRITE_SIDE_DEF,
  parameter int MAX_BYTES_PER_PIXEL = sbc_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sbc_in_if.sink                              in_ch,
  sbc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbc_pkg::*;

  localparam int CNT_W   = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;
  localparam int ENTRY_W = 2 * CNT_W + COLOR_W + 1;
  localparam logic [BPP_W-1:0] BPP_MAX  = BPP_W'(MAX_BYTES_PER_PIXEL);
  localparam logic [BPP_W-1:0] BPP_INIT =
    BPP_W'((MAX_BYTES_PER_PIXEL < RST_BPP) ? MAX_BYTES_PER_PIXEL : RST_BPP);
  localparam logic [DIM_W-1:0] SPR_MAX  = DIM_W'(MAX_SPRITE_SIDE);
  localparam logic [DIM_W-1:0] SCR_MAX  = DIM_W'(MAX_SCREEN_SIDE);

  sbc_cfg_t cfg_r, cfg_nxt;

  logic               q_push_valid;
  logic               q_push_ready;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  logic [ENTRY_W-1:0] q_pop_data;

  // registers keep the clamped value, which is all that is ever used
  always_comb begin
    logic [DIM_W-1:0]     scr_v;
    logic [SPR_CFG_W-1:0] spr_v;
    logic [DIM_W-1:0]     spr_clamp;
    logic [BPP_W-1:0]     bpp_v;
    logic [BPP_W-1:0]     bpp_clamp;
    scr_v     = cfg_wdata[DIM_W-1:0];
    spr_v     = cfg_wdata[SPR_CFG_W-1:0];
    bpp_v     = cfg_wdata[BPP_W-1:0];
    if (scr_v > SCR_MAX) begin
      scr_v = SCR_MAX;
    end
    if (spr_v == '0) begin
      spr_clamp = DIM_W'(1);
    end else if (DIM_W'(spr_v) > SPR_MAX) begin
      spr_clamp = SPR_MAX;
    end else begin
      spr_clamp = DIM_W'(spr_v);
    end
    if (bpp_v == '0) begin
      bpp_clamp = BPP_W'(1);
    end else if (bpp_v > BPP_MAX) begin
      bpp_clamp = BPP_MAX;
    end else begin
      bpp_clamp = bpp_v;
    end
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:    cfg_nxt.screen_w = scr_v;
        CFG_SCREEN_HEIGHT:   cfg_nxt.screen_h = scr_v;
        CFG_ORIGIN_X:        cfg_nxt.origin_x = cfg_wdata[ORG_W-1:0];
        CFG_ORIGIN_Y:        cfg_nxt.origin_y = cfg_wdata[ORG_W-1:0];
        CFG_SPRITE_WIDTH:    cfg_nxt.sprite_w = spr_clamp;
        CFG_SPRITE_HEIGHT:   cfg_nxt.sprite_h = spr_clamp;
        CFG_BYTES_PER_PIXEL: cfg_nxt.bpp      = bpp_clamp;
        CFG_CLIP_MODE:       cfg_nxt.clip     = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_w <= RST_SCREEN_W;
      cfg_r.screen_h <= RST_SCREEN_H;
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.sprite_w <= RST_SPRITE_W;
      cfg_r.sprite_h <= RST_SPRITE_H;
      cfg_r.bpp      <= BPP_INIT;
      cfg_r.clip     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbc_front #(
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL),
    .CNT_W               (CNT_W),
    .ENTRY_W             (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.src_byte),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  sbc_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  sbc_back #(
    .CNT_W   (CNT_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .pop_valid        (q_pop_valid),
    .pop_ready        (q_pop_ready),
    .pop_data         (q_pop_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_pixel_x      (out_ch.pixel_x),
    .out_pixel_y      (out_ch.pixel_y),
    .out_color        (out_ch.color),
    .out_write_enable (out_ch.write_enable),
    .out_rejected     (out_ch.rejected),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== sim/tb_sprite_blit_clip_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_blit_clip_unit
// Streams sprite source bytes into the blitter and checks every pixel request
// against an in-bench model of pixel assembly, clipping and rejection.
// ----------------------------------------------------------------------------

module tb_sprite_blit_clip_unit;
  import sbc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 40;
  localparam int IDLE_PCT      = 38;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               write_enable;
    logic               rejected;
    logic               last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sbc_in_if  src_ch ();
  sbc_out_if pix_ch ();

  sprite_blit_clip_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (src_ch),
    .out_ch    (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register shadows
  logic [DIM_W-1:0]     scr_w_reg, scr_h_reg;
  logic [ORG_W-1:0]     org_x_reg, org_y_reg;
  logic [SPR_CFG_W-1:0] spr_w_reg, spr_h_reg;
  logic [BPP_W-1:0]     bpp_reg;
  logic                 clip_reg;

  // blit position and partial colour
  logic [9:0]         col_pos, row_pos;
  logic [1:0]         byte_pos;
  logic [COLOR_W-1:0] color_acc;

  logic [BYTE_W-1:0] src_bytes[$];
  pixel_t            expected_pixels[$];
  pixel_t            next_pix;

  int src_gap_pct    = IDLE_PCT;
  int sink_stall_pct = IDLE_PCT;
  logic hold_go      = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int bytes_taken    = 0;
  int pixels_checked = 0;
  int setups_run     = 0;
  int mismatches     = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // folds one source byte into the current pixel; returns 1 when a pixel completes
  function automatic bit blit_byte(input logic [BYTE_W-1:0] b, output pixel_t pix);
    int unsigned bpp, w, h, sw, sh, bi, px, py;
    bit end_row, end_spr, fits;
    bpp = clamp_to(32'(bpp_reg), 1, MAX_BYTES_PER_PIXEL_DEF);
    w   = clamp_to(32'(spr_w_reg), 1, MAX_SPRITE_SIDE_DEF);
    h   = clamp_to(32'(spr_h_reg), 1, MAX_SPRITE_SIDE_DEF);
    sw  = clamp_to(32'(scr_w_reg), 0, MAX_SCREEN_SIDE);
    sh  = clamp_to(32'(scr_h_reg), 0, MAX_SCREEN_SIDE);
    bi  = 32'(byte_pos);
    color_acc = color_acc | (32'(b) << (8 * bi));
    if (bi + 1 < bpp) begin
      byte_pos = 2'(bi + 1);
      return 1'b0;
    end
    px = 32'(org_x_reg) + 32'(col_pos);
    py = 32'(org_y_reg) + 32'(row_pos);
    end_row = (32'(col_pos) + 1 >= w);
    end_spr = end_row && (32'(row_pos) + 1 >= h);
    if (clip_reg) begin
      pix.rejected     = 1'b0;
      pix.write_enable = (px < sw) && (py < sh);
    end else begin
      fits = (32'(org_x_reg) + w <= sw) && (32'(org_y_reg) + h <= sh);
      pix.rejected     = !fits;
      pix.write_enable = fits;
    end
    pix.pixel_x = 13'(px);
    pix.pixel_y = 13'(py);
    pix.color   = color_acc;
    pix.last    = end_spr;
    byte_pos  = '0;
    color_acc = '0;
    if (end_row) begin
      col_pos = '0;
      row_pos = end_spr ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got %0h, want %0h (pixel %0d)",
             $realtime, what, got, want, pixels_checked);
    mismatches++;
  endtask

  task automatic check_pixel();
    pixel_t want;
    pixels_checked++;
    if (expected_pixels.size() == 0) begin
      report_mismatch("unexpected pixel request, x", 64'(pix_ch.pixel_x), 0);
      return;
    end
    want = expected_pixels.pop_front();
    if (pix_ch.pixel_x !== want.pixel_x)
      report_mismatch("pixel_x", 64'(pix_ch.pixel_x), 64'(want.pixel_x));
    if (pix_ch.pixel_y !== want.pixel_y)
      report_mismatch("pixel_y", 64'(pix_ch.pixel_y), 64'(want.pixel_y));
    if (pix_ch.color !== want.color)
      report_mismatch("color", 64'(pix_ch.color), 64'(want.color));
    if (pix_ch.write_enable !== want.write_enable)
      report_mismatch("write_enable", 64'(pix_ch.write_enable), 64'(want.write_enable));
    if (pix_ch.rejected !== want.rejected)
      report_mismatch("rejected", 64'(pix_ch.rejected), 64'(want.rejected));
    if (pix_ch.last !== want.last)
      report_mismatch("last", 64'(pix_ch.last), 64'(want.last));
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      src_ch.valid    <= 1'b0;
      src_ch.src_byte <= '0;
    end else begin
      if (src_ch.valid && src_ch.ready) begin
        bytes_taken++;
        if (blit_byte(src_ch.src_byte, next_pix)) expected_pixels.push_back(next_pix);
      end
      if (src_ch.valid && !src_ch.ready) begin
        // request still pending, hold it
      end else if (src_bytes.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        src_ch.valid    <= 1'b1;
        src_ch.src_byte <= src_bytes.pop_front();
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) check_pixel();
      pix_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long sink hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d pixels outstanding",
             cycle_count, expected_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SCREEN_WIDTH:    scr_w_reg = value;
      CFG_SCREEN_HEIGHT:   scr_h_reg = value;
      CFG_ORIGIN_X:        org_x_reg = value[ORG_W-1:0];
      CFG_ORIGIN_Y:        org_y_reg = value[ORG_W-1:0];
      CFG_SPRITE_WIDTH:    spr_w_reg = value[SPR_CFG_W-1:0];
      CFG_SPRITE_HEIGHT:   spr_h_reg = value[SPR_CFG_W-1:0];
      CFG_BYTES_PER_PIXEL: bpp_reg   = value[BPP_W-1:0];
      CFG_CLIP_MODE:       clip_reg  = value[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    setups_run++;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (src_bytes.size() != 0 || src_ch.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_screen_side();
    case ($urandom_range(9))
      0: return '0;
      1: return 13'($urandom_range(4097, 8191));
      2: return 13'(MAX_SCREEN_SIDE);
      default: return 13'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    case ($urandom_range(7))
      0: return 13'd4095;
      1: return 13'($urandom_range(0, 4095));
      default: return 13'($urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_sprite_side();
    case ($urandom_range(11))
      0: return '0;
      1: return 13'($urandom_range(1024, 2047));
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_setup();
    if ($urandom_range(1)) write_reg(CFG_SCREEN_WIDTH, pick_screen_side());
    if ($urandom_range(1)) write_reg(CFG_SCREEN_HEIGHT, pick_screen_side());
    if ($urandom_range(1)) write_reg(CFG_ORIGIN_X, pick_origin());
    if ($urandom_range(1)) write_reg(CFG_ORIGIN_Y, pick_origin());
    if ($urandom_range(1)) write_reg(CFG_SPRITE_WIDTH, pick_sprite_side());
    if ($urandom_range(1)) write_reg(CFG_SPRITE_HEIGHT, pick_sprite_side());
    if ($urandom_range(1)) write_reg(CFG_BYTES_PER_PIXEL, 13'($urandom_range(0, 7)));
    if ($urandom_range(1)) write_reg(CFG_CLIP_MODE, 13'($urandom_range(1)));
    end_writes();
  endtask

  task automatic queue_random_bytes(int count);
    repeat (count) src_bytes.push_back(pick_byte());
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SCREEN_WIDTH;
    cfg_wdata      <= '0;
    scr_w_reg = RST_SCREEN_W;
    scr_h_reg = RST_SCREEN_H;
    org_x_reg = '0;
    org_y_reg = '0;
    spr_w_reg = SPR_CFG_W'(RST_SPRITE_W);
    spr_h_reg = SPR_CFG_W'(RST_SPRITE_H);
    bpp_reg   = BPP_W'(RST_BPP);
    clip_reg  = 1'b0;
    col_pos   = '0;
    row_pos   = '0;
    byte_pos  = '0;
    color_acc = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: 1x1 sprites of four bytes, fully on screen
    src_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
    settle();

    // clip across the saturated right edge and the bottom edge
    write_reg(CFG_SCREEN_WIDTH, 13'd8191);
    write_reg(CFG_SCREEN_HEIGHT, 13'd768);
    write_reg(CFG_ORIGIN_X, 13'd4094);
    write_reg(CFG_ORIGIN_Y, 13'd767);
    write_reg(CFG_SPRITE_WIDTH, 13'd3);
    write_reg(CFG_SPRITE_HEIGHT, 13'd2);
    write_reg(CFG_BYTES_PER_PIXEL, 13'd1);
    write_reg(CFG_CLIP_MODE, 13'd1);
    end_writes();
    src_bytes = '{8'h01, 8'h80, 8'hFF, 8'h00, 8'h55, 8'hAA};
    settle();

    // same placement without clipping: whole sprite rejected
    write_reg(CFG_CLIP_MODE, 13'd0);
    end_writes();
    src_bytes = '{8'h02, 8'h40, 8'h7F, 8'hFE, 8'h33, 8'hCC};
    settle();

    // zero screen; zero sprite sizes and bytes per pixel clamp up to one
    write_reg(CFG_SCREEN_WIDTH, 13'd0);
    write_reg(CFG_SCREEN_HEIGHT, 13'd0);
    write_reg(CFG_SPRITE_WIDTH, 13'd0);
    write_reg(CFG_SPRITE_HEIGHT, 13'd0);
    write_reg(CFG_BYTES_PER_PIXEL, 13'd0);
    write_reg(CFG_CLIP_MODE, 13'd1);
    end_writes();
    src_bytes = '{8'h11, 8'hEE};
    settle();
    write_reg(CFG_CLIP_MODE, 13'd0);
    end_writes();
    src_bytes = '{8'h5A};
    settle();

    // stop mid-pixel and mid-row, then shrink the bounds under the position
    write_reg(CFG_SCREEN_WIDTH, 13'd4096);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    write_reg(CFG_ORIGIN_X, 13'd0);
    write_reg(CFG_ORIGIN_Y, 13'd4095);
    write_reg(CFG_SPRITE_WIDTH, 13'd2047);
    write_reg(CFG_SPRITE_HEIGHT, 13'd1024);
    write_reg(CFG_BYTES_PER_PIXEL, 13'd3);
    end_writes();
    src_bytes = '{8'hA1, 8'hB2, 8'hC3, 8'hD4};
    settle();
    write_reg(CFG_SPRITE_WIDTH, 13'd1);
    write_reg(CFG_BYTES_PER_PIXEL, 13'd2);
    end_writes();
    src_bytes = '{8'hE5};
    settle();
    write_reg(CFG_SPRITE_HEIGHT, 13'd1);
    end_writes();
    src_bytes = '{8'h96, 8'h69};
    settle();

    // random setups with random byte streams
    for (int phase = 0; phase < 14; phase++) begin
      random_setup();
      if (phase == 6) begin
        // no idling on either side for this stretch
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      queue_random_bytes($urandom_range(20, 44));
      settle();
      src_gap_pct    = IDLE_PCT;
      sink_stall_pct = IDLE_PCT;
    end

    // sink holds off while bytes keep coming, so the block backs up
    write_reg(CFG_SCREEN_WIDTH, 13'd16);
    write_reg(CFG_SCREEN_HEIGHT, 13'd1);
    write_reg(CFG_ORIGIN_X, 13'd0);
    write_reg(CFG_ORIGIN_Y, 13'd0);
    write_reg(CFG_SPRITE_WIDTH, 13'd5);
    write_reg(CFG_SPRITE_HEIGHT, 13'd3);
    write_reg(CFG_BYTES_PER_PIXEL, 13'd1);
    write_reg(CFG_CLIP_MODE, 13'd1);
    end_writes();
    src_gap_pct = 0;
    queue_random_bytes(60);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    settle();
    src_gap_pct = IDLE_PCT;

    $display("run covered %0d source bytes and %0d pixel requests over %0d register setups",
             bytes_taken, pixels_checked, setups_run);
    $display("clip and reject modes, clamped sizes and mid-sprite rewrites included; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
